// ===== sv/box_signed_distance_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BOX_SIGNED_DISTANCE_DEFINES_SVH
`define BOX_SIGNED_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("box_signed_distance: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define BSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("box_signed_distance: next-cycle check failed");

`endif

// ===== sv/bsd_pkg.sv =====
package bsd_pkg;

  localparam int NUM_AXES = 3;
  localparam int COORD_W  = 32;
  localparam int HALF_W   = 31;
  localparam int SQ_W     = 62;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int REM_W    = 33;
  localparam int ADDR_W   = 5;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_HALF_X   = 3'd3;
  localparam logic [2:0] REG_HALF_Y   = 3'd4;
  localparam logic [2:0] REG_HALF_Z   = 3'd5;

  localparam logic signed [COORD_W-1:0] S32_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] S32_MIN    = 32'sh8000_0000;
  localparam logic [HALF_W-1:0]         HALF_RESET = 31'd65536;

  // Side data carried alongside the root
  typedef struct packed {
    logic signed [COORD_W-1:0] qadj;  // min(max q, 0)
    logic                      clip;
  } side_t;

  // One step of the digit-by-digit square root
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_step_t;

  function automatic sqrt_step_t sqrt_step(input sqrt_step_t s);
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    sqrt_step_t       o;
    rem_sh = {s.rem, s.rad[RAD_W-1:RAD_W-2]};
    trial  = {1'b0, s.root, 2'b01};
    o.rad  = {s.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      o.rem  = REM_W'(rem_sh - trial);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem_sh[REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Saturate a 34-bit signed value to 32 bits; returns {clip, value}
  function automatic logic [COORD_W:0] sat_s32(input logic signed [COORD_W+1:0] v);
    logic [COORD_W:0] r;
    if (v[COORD_W+1:COORD_W-1] == 3'b000 || v[COORD_W+1:COORD_W-1] == 3'b111) begin
      r = {1'b0, v[COORD_W-1:0]};
    end else if (v[COORD_W+1]) begin
      r = {1'b1, S32_MIN};
    end else begin
      r = {1'b1, S32_MAX};
    end
    return r;
  endfunction

endpackage

// ===== sv/bsd_sqrt.sv =====
module bsd_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsd_pkg::RAD_W-1:0]     in_rad,
  input  bsd_pkg::side_t                in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bsd_pkg::ROOT_W-1:0]    out_root,
  output bsd_pkg::side_t                out_side
);
  import bsd_pkg::*;

  localparam int STEPS = ROOT_W;

  logic [STEPS-1:0] v_r;
  logic [STEPS-1:0] prev_v;
  logic [STEPS-1:0] rdy;
  sqrt_step_t       st_r   [STEPS];
  side_t            side_r [STEPS];
  sqrt_step_t       prev_st   [STEPS];
  side_t            prev_side [STEPS];

  // A stage advances when it or any later stage holds a bubble or the sink takes an item
  for (genvar k = 0; k < STEPS; k++) begin : g_rdy
    assign rdy[k] = out_ready | ~(&v_r[STEPS-1:k]);
  end

  assign prev_v = {v_r[STEPS-2:0], in_valid};

  always_comb begin
    prev_st[0]   = '{rad: in_rad, rem: '0, root: '0};
    prev_side[0] = in_side;
    for (int k = 1; k < STEPS; k++) begin
      prev_st[k]   = st_r[k-1];
      prev_side[k] = side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < STEPS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= prev_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STEPS; k++) begin
      if (rdy[k]) begin
        st_r[k]   <= sqrt_step(prev_st[k]);
        side_r[k] <= prev_side[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[STEPS-1];
  assign out_root  = st_r[STEPS-1].root;
  assign out_side  = side_r[STEPS-1];

endmodule

// ===== sv/box_signed_distance.sv =====
// Channel | Direction | Ports                                   | Content
// input   | in        | in_tvalid, in_tready, in_tdata[95:0]    | point_x, point_y, point_z
// result  | out       | out_tvalid, out_tready, out_tdata[31:0],| distance, clipped (tuser)
//         |           | out_tuser[0:0]                          |
// config  | in        | psel, penable, pwrite, paddr, pwdata,   | box center and half-extents
//         |           | prdata, pready                          |
//
// One item enters per cycle while in_tready is high; the path runs through 5 front stages,
// 32 root stages and the output register. The square root resolves one result bit per stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default box
// (center 0, half-extents 1.0). A stalled output holds its item; earlier stages keep
// advancing into bubbles, so in_tready stays high while any stage is empty.
module box_signed_distance (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] point_x, [63:32] point_y, [95:64] point_z
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] distance
  output logic [0:0]  out_tuser,  // [0] clipped
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsd_pkg::*;

  localparam int FRONT = 5;

  // Configuration registers
  logic signed [COORD_W-1:0] center_r [NUM_AXES];
  logic [HALF_W-1:0]         half_r   [NUM_AXES];

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        center_r[a] <= '0;
        half_r[a]   <= HALF_RESET;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CENTER_X: center_r[0] <= pwdata;
        REG_CENTER_Y: center_r[1] <= pwdata;
        REG_CENTER_Z: center_r[2] <= pwdata;
        REG_HALF_X:   half_r[0]   <= pwdata[HALF_W-1:0];
        REG_HALF_Y:   half_r[1]   <= pwdata[HALF_W-1:0];
        REG_HALF_Z:   half_r[2]   <= pwdata[HALF_W-1:0];
        default: ;    // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CENTER_X: prdata = center_r[0];
      REG_CENTER_Y: prdata = center_r[1];
      REG_CENTER_Z: prdata = center_r[2];
      REG_HALF_X:   prdata = {1'b0, half_r[0]};
      REG_HALF_Y:   prdata = {1'b0, half_r[1]};
      REG_HALF_Z:   prdata = {1'b0, half_r[2]};
      default:      prdata = '0;
    endcase
  end

  // Pipeline control: bit k is the valid of front stage k+1
  logic [FRONT-1:0] front_v_r;
  logic [FRONT-1:0] front_rdy;
  logic             sq_in_ready;
  logic             sq_out_valid;
  logic             out_rdy;
  logic             out_v_r;

  // Advance a stage when it or a later stage has a bubble or the next block takes an item
  for (genvar k = 0; k < FRONT; k++) begin : g_front_rdy
    assign front_rdy[k] = sq_in_ready | ~(&front_v_r[FRONT-1:k]);
  end

  assign out_rdy   = out_tready | ~out_v_r;
  assign in_tready = front_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= '0;
    end else begin
      if (front_rdy[0]) front_v_r[0] <= in_tvalid;
      for (int k = 1; k < FRONT; k++) begin
        if (front_rdy[k]) front_v_r[k] <= front_v_r[k-1];
      end
    end
  end

  // Stage 1: d = p - c, saturated
  logic signed [COORD_W-1:0] d_nxt [NUM_AXES];
  logic signed [COORD_W-1:0] d_r   [NUM_AXES];
  logic                      clip1_nxt, clip1_r;

  always_comb begin
    logic signed [COORD_W-1:0] p;
    logic signed [COORD_W+1:0] diff;
    logic [COORD_W:0]          s;
    clip1_nxt = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      p         = in_tdata[a*COORD_W +: COORD_W];
      diff      = {{2{p[COORD_W-1]}}, p} - {{2{center_r[a][COORD_W-1]}}, center_r[a]};
      s         = sat_s32(diff);
      d_nxt[a]  = s[COORD_W-1:0];
      clip1_nxt = clip1_nxt | s[COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (front_rdy[0]) begin
      d_r     <= d_nxt;
      clip1_r <= clip1_nxt;
    end
  end

  // Stage 2: |d|, the most negative value saturates to the largest positive
  logic [HALF_W-1:0] a_nxt [NUM_AXES];
  logic [HALF_W-1:0] a_r   [NUM_AXES];
  logic              clip2_nxt, clip2_r;

  always_comb begin
    logic signed [COORD_W-1:0] neg;
    clip2_nxt = clip1_r;
    for (int a = 0; a < NUM_AXES; a++) begin
      neg = -d_r[a];
      if (d_r[a] == S32_MIN) begin
        a_nxt[a]  = '1;
        clip2_nxt = 1'b1;
      end else if (d_r[a][COORD_W-1]) begin
        a_nxt[a] = neg[HALF_W-1:0];
      end else begin
        a_nxt[a] = d_r[a][HALF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (front_rdy[1]) begin
      a_r     <= a_nxt;
      clip2_r <= clip2_nxt;
    end
  end

  // Stage 3: q = |d| - half, always within 32-bit range
  logic signed [COORD_W-1:0] q_nxt [NUM_AXES];
  logic signed [COORD_W-1:0] q_r   [NUM_AXES];
  logic                      clip3_r;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      q_nxt[a] = {1'b0, a_r[a]} - {1'b0, half_r[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (front_rdy[2]) begin
      q_r     <= q_nxt;
      clip3_r <= clip2_r;
    end
  end

  // Stage 4: square the positive parts, find max q
  logic [SQ_W-1:0]           sq_nxt [NUM_AXES];
  logic [SQ_W-1:0]           sq_r   [NUM_AXES];
  logic signed [COORD_W-1:0] qadj_nxt, qadj4_r;
  logic                      clip4_r;

  always_comb begin
    logic [HALF_W-1:0]         qp;
    logic signed [COORD_W-1:0] m01;
    logic signed [COORD_W-1:0] qmax;
    for (int a = 0; a < NUM_AXES; a++) begin
      qp        = (q_r[a] > 0) ? q_r[a][HALF_W-1:0] : '0;
      sq_nxt[a] = SQ_W'(qp) * SQ_W'(qp);
    end
    m01      = (q_r[1] > q_r[0]) ? q_r[1] : q_r[0];
    qmax     = (q_r[2] > m01) ? q_r[2] : m01;
    qadj_nxt = qmax[COORD_W-1] ? qmax : '0;
  end

  always_ff @(posedge clk) begin
    if (front_rdy[3]) begin
      sq_r    <= sq_nxt;
      qadj4_r <= qadj_nxt;
      clip4_r <= clip3_r;
    end
  end

  // Stage 5: sum of squares, feeds the root pipeline
  logic [RAD_W-1:0] sum_r;
  side_t            side5_r;

  always_ff @(posedge clk) begin
    if (front_rdy[4]) begin
      sum_r        <= RAD_W'(sq_r[0]) + RAD_W'(sq_r[1]) + RAD_W'(sq_r[2]);
      side5_r.qadj <= qadj4_r;
      side5_r.clip <= clip4_r;
    end
  end

  logic [ROOT_W-1:0] root;
  side_t             sq_side;

  bsd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (front_v_r[FRONT-1]),
    .in_ready (sq_in_ready),
    .in_rad   (sum_r),
    .in_side  (side5_r),
    .out_valid(sq_out_valid),
    .out_ready(out_rdy),
    .out_root (root),
    .out_side (sq_side)
  );

  // Output stage: root + min(max q, 0), saturated
  logic signed [COORD_W+1:0] res;
  logic [COORD_W:0]          res_sat;
  logic signed [COORD_W-1:0] dist_r;
  logic                      clip_r;

  assign res     = {2'b00, root} + {{2{sq_side.qadj[COORD_W-1]}}, sq_side.qadj};
  assign res_sat = sat_s32(res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= sq_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      dist_r <= res_sat[COORD_W-1:0];
      clip_r <= sq_side.clip | res_sat[COORD_W];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = dist_r;
  assign out_tuser  = clip_r;

endmodule

// ===== sv/bsd_checker.sv =====
`include "box_signed_distance_defines.svh"

module bsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // A stalled result holds
  `BSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // An empty output register never blocks the input
  `BSD_ASSERT_IMP(a_idle_ready, clk, rst_n, !out_tvalid, in_tready)

  // A result taken this cycle frees every stage
  `BSD_ASSERT_IMP(a_take_ready, clk, rst_n, out_tvalid && out_tready, in_tready)

  // The distance is bounded below by -(2^31 - 1)
  `BSD_ASSERT_IMP(a_no_min, clk, rst_n, out_tvalid, out_tdata != 32'h8000_0000)

endmodule

bind box_signed_distance bsd_checker u_bsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
